### src/trrjt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trrjt_pkg
// Shared types and constants for the timed round-robin job table.
// ----------------------------------------------------------------------------
package trrjt_pkg;

   localparam int CON_W      = 8;
   localparam int LED_W      = 8;
   localparam int TICK_W     = 16;
   localparam int MODE_W     = 3;
   localparam int SLOT_W     = 3;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 24;

   localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FIND   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ALLOC  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_EMIT   = 3'd4;

   typedef struct packed {
      logic [CON_W-1:0]  con;
      logic [LED_W-1:0]  led;
      logic [TICK_W-1:0] next_tick;
   } job_entry_type;

   typedef struct packed {
      logic en_fields;
      logic en_tick;
   } mem_wr_type;

   typedef struct packed {
      logic take;
      logic drop;
   } match_type;

endpackage
`default_nettype wire

### src/timed_round_robin_job_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// timed_round_robin_job_table
// Job table with find, allocate, remove and round-robin timed emit.
// One command word at a time: req_tready stays low from acceptance until the
// response word is registered. The scan reads one slot per cycle from the job
// memory through the shared compare unit.
// Reset clears the active marks, the pointer and the streaming flag at once.
// ----------------------------------------------------------------------------
module timed_round_robin_job_table #(
   parameter int JOB_SLOTS = 8
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   // mode[2:0], con[10:3], led[18:11], tick[34:19], zero pad
   input  wire logic [trrjt_pkg::REQ_DATA_W-1:0] req_tdata,
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   // hit[0], slot[3:1], out_con[11:4], out_led[19:12], any_active[20], zero pad
   output      logic [trrjt_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int IDX_W = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
   localparam int CNT_W = $clog2(JOB_SLOTS + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_type;

   state_type                         state_ff, state_in;
   logic [trrjt_pkg::MODE_W-1:0]      mode_ff, mode_in;
   logic [trrjt_pkg::CON_W-1:0]       con_ff, con_in;
   logic [trrjt_pkg::LED_W-1:0]       led_ff, led_in;
   logic [trrjt_pkg::TICK_W-1:0]      tick_ff, tick_in;
   logic [JOB_SLOTS-1:0]              active_ff, active_in;
   logic [IDX_W-1:0]                  rr_ff, rr_in;
   logic                              stream_ff, stream_in;
   logic [IDX_W-1:0]                  issue_idx_ff, issue_idx_in;
   logic [CNT_W-1:0]                  issue_cnt_ff, issue_cnt_in;
   logic                              rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]                  rd_idx_ff, rd_idx_in;
   logic                              rd_last_ff, rd_last_in;
   logic                              res_hit_ff, res_hit_in;
   logic [trrjt_pkg::SLOT_W-1:0]      res_slot_ff, res_slot_in;
   logic [trrjt_pkg::CON_W-1:0]       res_con_ff, res_con_in;
   logic [trrjt_pkg::LED_W-1:0]       res_led_ff, res_led_in;
   logic                              rsp_vld_ff, rsp_vld_in;
   logic [trrjt_pkg::RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic                              req_acc;
   logic [trrjt_pkg::MODE_W-1:0]      req_mode;
   trrjt_pkg::mem_wr_type             mem_wr;
   trrjt_pkg::job_entry_type          mem_wr_data;
   trrjt_pkg::job_entry_type          mem_rd_data;
   trrjt_pkg::match_type              match;
   logic [IDX_W-1:0]                  rd_idx_next;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign req_mode   = req_tdata[2:0];
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign rd_idx_next = (rd_idx_ff == IDX_W'(JOB_SLOTS - 1)) ? '0 : rd_idx_ff + 1'b1;

   trrjt_job_mem #(
      .DEPTH  (JOB_SLOTS),
      .ADDR_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .wr_addr (rd_idx_ff),
      .wr_data (mem_wr_data),
      .rd_addr (issue_idx_ff),
      .rd_data (mem_rd_data)
   );

   trrjt_match_unit u_match (
      .mode     (mode_ff),
      .active   (active_ff[rd_idx_ff]),
      .entry    (mem_rd_data),
      .cmd_con  (con_ff),
      .cmd_led  (led_ff),
      .cmd_tick (tick_ff),
      .result   (match)
   );

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      con_in       = con_ff;
      led_in       = led_ff;
      tick_in      = tick_ff;
      active_in    = active_ff;
      rr_in        = rr_ff;
      stream_in    = stream_ff;
      issue_idx_in = issue_idx_ff;
      issue_cnt_in = issue_cnt_ff;
      rd_vld_in    = rd_vld_ff;
      rd_idx_in    = rd_idx_ff;
      rd_last_in   = rd_last_ff;
      res_hit_in   = res_hit_ff;
      res_slot_in  = res_slot_ff;
      res_con_in   = res_con_ff;
      res_led_in   = res_led_ff;
      rsp_vld_in   = rsp_vld_ff;
      rsp_data_in  = rsp_data_ff;
      mem_wr       = '0;
      mem_wr_data.con       = con_ff;
      mem_wr_data.led       = led_ff;
      mem_wr_data.next_tick = tick_ff;

      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               mode_in      = req_mode;
               con_in       = req_tdata[10:3];
               led_in       = req_tdata[18:11];
               tick_in      = req_tdata[34:19];
               res_hit_in   = 1'b0;
               res_slot_in  = '0;
               res_con_in   = '0;
               res_led_in   = '0;
               rd_vld_in    = 1'b0;
               rd_last_in   = 1'b0;
               issue_cnt_in = '0;
               issue_idx_in = (req_mode == trrjt_pkg::MODE_EMIT) ? rr_ff : '0;
               case (req_mode)
                  trrjt_pkg::MODE_CLEAR: begin
                     active_in = '0;
                     state_in  = ST_FINISH;
                  end
                  trrjt_pkg::MODE_REMOVE,
                  trrjt_pkg::MODE_FIND,
                  trrjt_pkg::MODE_ALLOC: begin
                     state_in = ST_SCAN;
                  end
                  trrjt_pkg::MODE_EMIT: begin
                     stream_in = |active_ff;
                     state_in  = (|active_ff) ? ST_SCAN : ST_FINISH;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // read issue, one slot per cycle
            rd_vld_in = 1'b0;
            if (issue_cnt_ff != CNT_W'(JOB_SLOTS)) begin
               rd_vld_in    = 1'b1;
               rd_idx_in    = issue_idx_ff;
               rd_last_in   = (issue_cnt_ff == CNT_W'(JOB_SLOTS - 1));
               issue_cnt_in = issue_cnt_ff + 1'b1;
               issue_idx_in = (issue_idx_ff == IDX_W'(JOB_SLOTS - 1)) ?
                              '0 : issue_idx_ff + 1'b1;
            end
            // evaluate the word read last cycle
            if (rd_vld_ff) begin
               if (match.drop) begin
                  active_in[rd_idx_ff] = 1'b0;
               end
               if (match.take) begin
                  res_hit_in  = 1'b1;
                  res_slot_in = trrjt_pkg::SLOT_W'(rd_idx_ff);
                  state_in    = ST_FINISH;
                  if (mode_ff == trrjt_pkg::MODE_ALLOC) begin
                     mem_wr.en_fields     = 1'b1;
                     active_in[rd_idx_ff] = 1'b1;
                  end else if (mode_ff == trrjt_pkg::MODE_EMIT) begin
                     mem_wr.en_tick        = 1'b1;
                     mem_wr_data.next_tick = tick_ff + 1'b1;
                     res_con_in            = mem_rd_data.con;
                     res_led_in            = mem_rd_data.led;
                     rr_in                 = rd_idx_next;
                  end
               end else if (rd_last_ff) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = {3'b000, stream_ff, res_led_ff, res_con_ff,
                              res_slot_ff, res_hit_ff};
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         active_ff  <= '0;
         rr_ff      <= '0;
         stream_ff  <= 1'b0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         active_ff  <= active_in;
         rr_ff      <= rr_in;
         stream_ff  <= stream_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      mode_ff      <= mode_in;
      con_ff       <= con_in;
      led_ff       <= led_in;
      tick_ff      <= tick_in;
      issue_idx_ff <= issue_idx_in;
      issue_cnt_ff <= issue_cnt_in;
      rd_idx_ff    <= rd_idx_in;
      rd_last_ff   <= rd_last_in;
      res_hit_ff   <= res_hit_in;
      res_slot_ff  <= res_slot_in;
      res_con_ff   <= res_con_in;
      res_led_ff   <= res_led_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule
`default_nettype wire

### src/trrjt_job_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trrjt_job_mem
// Job entry storage: one write port with field enables, one registered read.
// ----------------------------------------------------------------------------
module trrjt_job_mem #(
   parameter int DEPTH  = 8,
   parameter int ADDR_W = 3
) (
   input  wire logic                     clock,
   input  wire trrjt_pkg::mem_wr_type    wr,
   input  wire logic [ADDR_W-1:0]        wr_addr,
   input  wire trrjt_pkg::job_entry_type wr_data,
   input  wire logic [ADDR_W-1:0]        rd_addr,
   output      trrjt_pkg::job_entry_type rd_data
);

   logic [trrjt_pkg::CON_W-1:0]  con_mem  [DEPTH];
   logic [trrjt_pkg::LED_W-1:0]  led_mem  [DEPTH];
   logic [trrjt_pkg::TICK_W-1:0] tick_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en_fields) begin
         con_mem[wr_addr] <= wr_data.con;
         led_mem[wr_addr] <= wr_data.led;
      end
      if (wr.en_fields || wr.en_tick) begin
         tick_mem[wr_addr] <= wr_data.next_tick;
      end
      rd_data.con       <= con_mem[rd_addr];
      rd_data.led       <= led_mem[rd_addr];
      rd_data.next_tick <= tick_mem[rd_addr];
   end

endmodule
`default_nettype wire

### src/trrjt_match_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trrjt_match_unit
// Shared compare unit: judges one job entry against the current command.
// ----------------------------------------------------------------------------
module trrjt_match_unit (
   input  wire logic [trrjt_pkg::MODE_W-1:0] mode,
   input  wire logic                         active,
   input  wire trrjt_pkg::job_entry_type     entry,
   input  wire logic [trrjt_pkg::CON_W-1:0]  cmd_con,
   input  wire logic [trrjt_pkg::LED_W-1:0]  cmd_led,
   input  wire logic [trrjt_pkg::TICK_W-1:0] cmd_tick,
   output      trrjt_pkg::match_type         result
);

   logic                         con_eq;
   logic                         led_eq;
   logic [trrjt_pkg::TICK_W-1:0] diff;
   logic                         reached;

   assign con_eq  = (entry.con == cmd_con);
   assign led_eq  = (entry.led == cmd_led);
   assign diff    = cmd_tick - entry.next_tick;
   // wrapping signed difference, due when non-negative
   assign reached = ~diff[trrjt_pkg::TICK_W-1];

   always_comb begin
      result = '0;
      case (mode)
         trrjt_pkg::MODE_REMOVE: result.drop = active && con_eq && !led_eq;
         trrjt_pkg::MODE_FIND:   result.take = active && con_eq && led_eq;
         trrjt_pkg::MODE_ALLOC:  result.take = !active;
         trrjt_pkg::MODE_EMIT:   result.take = active && reached;
         default:                result = '0;
      endcase
   end

endmodule
`default_nettype wire

### src/trrjt_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trrjt_checker
// Port-level checks for the timed round-robin job table.
// ----------------------------------------------------------------------------
module trrjt_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic [trrjt_pkg::REQ_DATA_W-1:0] req_tdata,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [trrjt_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second req word taken while busy");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[19:1] == 19'd0)
      else $error("miss word carries slot or job data");

endmodule

bind timed_round_robin_job_table trrjt_checker u_trrjt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

### test/timed_round_robin_job_table_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// timed_round_robin_job_table_tb
// Self-checking bench for the timed round-robin job table.
// Command words go in on req_, response words come back on rsp_. A shadow of
// the job table, the round-robin pointer and the streaming flag predicts
// every response, and each response is checked field by field in order.
// Directed corner cases run first, then random traffic built around a tick
// that moves forward, with random stalls on both sides outside the back-to-back run.
// ----------------------------------------------------------------------------
module timed_round_robin_job_table_tb;

   localparam int JOB_SLOTS    = 8;
   localparam int REQ_PAD_W    = trrjt_pkg::REQ_DATA_W - trrjt_pkg::MODE_W -
                                 trrjt_pkg::CON_W - trrjt_pkg::LED_W - trrjt_pkg::TICK_W;
   localparam int RSP_PAD_W    = trrjt_pkg::RSP_DATA_W - trrjt_pkg::SLOT_W -
                                 trrjt_pkg::CON_W - trrjt_pkg::LED_W - 2;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 16;

   localparam logic [trrjt_pkg::MODE_W-1:0] MODE_SPARE_5 = 3'd5;
   localparam logic [trrjt_pkg::MODE_W-1:0] MODE_SPARE_6 = 3'd6;
   localparam logic [trrjt_pkg::MODE_W-1:0] MODE_SPARE_7 = 3'd7;

   // rsp_tdata layout, lowest field last
   typedef struct packed {
      logic [RSP_PAD_W-1:0]            pad;
      logic                            any_active;
      logic [trrjt_pkg::LED_W-1:0]     out_led;
      logic [trrjt_pkg::CON_W-1:0]     out_con;
      logic [trrjt_pkg::SLOT_W-1:0]    slot;
      logic                            hit;
   } table_rsp_type;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [trrjt_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [trrjt_pkg::RSP_DATA_W-1:0] rsp_tdata;

   // shadow job table
   logic [JOB_SLOTS-1:0]         job_live;
   logic [trrjt_pkg::CON_W-1:0]  job_con [JOB_SLOTS];
   logic [trrjt_pkg::LED_W-1:0]  job_led [JOB_SLOTS];
   logic [trrjt_pkg::TICK_W-1:0] job_due [JOB_SLOTS];
   int                           rr_next;
   logic                         stream_flag;

   table_rsp_type                pending_rsp_q[$];
   logic [trrjt_pkg::TICK_W-1:0] now_tick;
   bit                           tx_idle;
   bit                           rx_idle;
   int unsigned                  cycle_count = 0;
   int unsigned                  mismatches;
   int unsigned                  words_sent;
   int unsigned                  rsp_checked;
   int unsigned                  emits_issued;
   int unsigned                  find_hits;
   int unsigned                  alloc_full;

   timed_round_robin_job_table #(
      .JOB_SLOTS(JOB_SLOTS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d responses still outstanding", $time,
                  pending_rsp_q.size());
         $display("Verification failed");
         $finish;
      end
   end

   // Applies one command to the shadow table, returns the expected response.
   function automatic table_rsp_type apply_job_cmd(
      input logic [trrjt_pkg::MODE_W-1:0] m,
      input logic [trrjt_pkg::CON_W-1:0]  c,
      input logic [trrjt_pkg::LED_W-1:0]  l,
      input logic [trrjt_pkg::TICK_W-1:0] t);
      table_rsp_type                r;
      int                           i;
      int                           j;
      logic [trrjt_pkg::TICK_W-1:0] age;
      r = '0;
      case (m)
         trrjt_pkg::MODE_CLEAR: begin
            job_live = '0;
         end
         trrjt_pkg::MODE_REMOVE: begin
            for (i = 0; i < JOB_SLOTS; i++)
               if (job_live[i] && job_con[i] == c && job_led[i] != l) job_live[i] = 1'b0;
         end
         trrjt_pkg::MODE_FIND: begin
            for (i = 0; i < JOB_SLOTS && !r.hit; i++)
               if (job_live[i] && job_con[i] == c && job_led[i] == l) begin
                  r.hit  = 1'b1;
                  r.slot = trrjt_pkg::SLOT_W'(i);
               end
            if (r.hit) find_hits++;
         end
         trrjt_pkg::MODE_ALLOC: begin
            for (i = 0; i < JOB_SLOTS && !r.hit; i++)
               if (!job_live[i]) begin
                  job_live[i] = 1'b1;
                  job_con[i]  = c;
                  job_led[i]  = l;
                  job_due[i]  = t;
                  r.hit       = 1'b1;
                  r.slot      = trrjt_pkg::SLOT_W'(i);
               end
            if (!r.hit) alloc_full++;
         end
         trrjt_pkg::MODE_EMIT: begin
            stream_flag = |job_live;
            for (i = 0; i < JOB_SLOTS && stream_flag && !r.hit; i++) begin
               j = (rr_next + i) % JOB_SLOTS;
               if (job_live[j]) begin
                  // due when the wrapped difference is non-negative
                  age = t - job_due[j];
                  if (!age[trrjt_pkg::TICK_W-1]) begin
                     r.hit      = 1'b1;
                     r.slot     = trrjt_pkg::SLOT_W'(j);
                     r.out_con  = job_con[j];
                     r.out_led  = job_led[j];
                     job_due[j] = t + 1'b1;
                     rr_next    = (j + 1) % JOB_SLOTS;
                     emits_issued++;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      r.any_active = stream_flag;
      return r;
   endfunction

   task automatic send_word(input logic [trrjt_pkg::MODE_W-1:0] m,
                            input logic [trrjt_pkg::CON_W-1:0]  c,
                            input logic [trrjt_pkg::LED_W-1:0]  l,
                            input logic [trrjt_pkg::TICK_W-1:0] t);
      if (tx_idle && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{REQ_PAD_W{1'b0}}, t, l, c, m};
      do @(posedge clock); while (!req_tready);
      pending_rsp_q.push_back(apply_job_cmd(m, c, l, t));
      words_sent++;
   endtask

   task automatic wait_all_returned();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_rsp_q.size() != 0);
   endtask

   task automatic send_random_cmd(input bit heavy_emit);
      logic [trrjt_pkg::MODE_W-1:0] m;
      logic [trrjt_pkg::CON_W-1:0]  c;
      logic [trrjt_pkg::LED_W-1:0]  l;
      logic [trrjt_pkg::TICK_W-1:0] t;
      int unsigned                  pick;
      int unsigned                  k;
      pick = $urandom_range(0, 99);
      if (heavy_emit && pick < 40) m = trrjt_pkg::MODE_EMIT;
      else if (pick < 2)           m = trrjt_pkg::MODE_CLEAR;
      else if (pick < 12)          m = trrjt_pkg::MODE_REMOVE;
      else if (pick < 27)          m = trrjt_pkg::MODE_FIND;
      else if (pick < 50)          m = trrjt_pkg::MODE_ALLOC;
      else if (pick < 97)          m = trrjt_pkg::MODE_EMIT;
      else m = trrjt_pkg::MODE_W'($urandom_range(MODE_SPARE_5, MODE_SPARE_7));

      // small key pool so find and remove actually match
      if ($urandom_range(0, 4) == 0) begin
         c = trrjt_pkg::CON_W'($urandom);
         l = trrjt_pkg::LED_W'($urandom);
      end else begin
         case ($urandom_range(0, 3))
            0:       c = '0;
            1:       c = '1;
            default: c = trrjt_pkg::CON_W'($urandom_range(1, 3));
         endcase
         l = trrjt_pkg::LED_W'($urandom_range(0, 3));
      end
      if ((m == trrjt_pkg::MODE_FIND || m == trrjt_pkg::MODE_REMOVE) &&
          $urandom_range(0, 1) == 1) begin
         k = $urandom_range(0, JOB_SLOTS - 1);
         if (job_live[k]) begin
            c = job_con[k];
            l = job_led[k];
         end
      end

      case (m)
         trrjt_pkg::MODE_EMIT: begin
            if ($urandom_range(0, 99) == 0) now_tick = trrjt_pkg::TICK_W'($urandom);
            else now_tick = now_tick + trrjt_pkg::TICK_W'($urandom_range(0, 2));
            t = now_tick;
         end
         trrjt_pkg::MODE_ALLOC: begin
            case ($urandom_range(0, 9))
               0:       t = now_tick + 16'h7fff;
               1:       t = now_tick + 16'h8000;
               2:       t = now_tick + 16'h8001;
               3:       t = trrjt_pkg::TICK_W'($urandom);
               default: t = now_tick + trrjt_pkg::TICK_W'($urandom_range(0, 6));
            endcase
         end
         default: t = trrjt_pkg::TICK_W'($urandom);
      endcase
      send_word(m, c, l, t);
   endtask

   task automatic test_directed();
      send_word(trrjt_pkg::MODE_EMIT,   8'h00, 8'h00, 16'h0000);   // empty table
      send_word(MODE_SPARE_5,           8'hff, 8'hff, 16'hffff);
      send_word(MODE_SPARE_6,           8'h5a, 8'ha5, 16'h5555);
      send_word(MODE_SPARE_7,           8'hff, 8'hff, 16'hffff);
      send_word(trrjt_pkg::MODE_FIND,   8'h00, 8'h00, 16'h0000);   // miss on empty
      send_word(trrjt_pkg::MODE_ALLOC,  8'h00, 8'h00, 16'hffff);
      send_word(trrjt_pkg::MODE_ALLOC,  8'hff, 8'hff, 16'h8000);
      for (int n = 1; n <= 6; n++)
         send_word(trrjt_pkg::MODE_ALLOC, 8'h07, trrjt_pkg::LED_W'(n), 16'h0010);
      send_word(trrjt_pkg::MODE_ALLOC,  8'h33, 8'h44, 16'h0000);   // table full
      send_word(trrjt_pkg::MODE_FIND,   8'hff, 8'hff, 16'h0000);
      send_word(trrjt_pkg::MODE_FIND,   8'h07, 8'h09, 16'h0000);
      send_word(trrjt_pkg::MODE_EMIT,   8'h00, 8'h00, 16'h0000);   // due across wrap
      send_word(trrjt_pkg::MODE_EMIT,   8'h00, 8'h00, 16'h0000);   // nothing due
      send_word(trrjt_pkg::MODE_EMIT,   8'h00, 8'h00, 16'h7fff);
      send_word(trrjt_pkg::MODE_REMOVE, 8'h07, 8'h03, 16'h0000);   // keeps led 3 only
      send_word(trrjt_pkg::MODE_EMIT,   8'h00, 8'h00, 16'h8000);
      send_word(trrjt_pkg::MODE_CLEAR,  8'h00, 8'h00, 16'h0000);
      send_word(trrjt_pkg::MODE_EMIT,   8'h00, 8'h00, 16'h8001);   // flag drops
   endtask

   task automatic test_random_mix(input int unsigned count);
      for (int unsigned n = 0; n < count; n++) begin
         if (n % 50 == 0) begin
            tx_idle = $urandom_range(0, 2) != 0;
            rx_idle = $urandom_range(0, 2) != 0;
         end
         send_random_cmd(1'b0);
      end
   endtask

   task automatic test_drain_between_bursts();
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      repeat (4) begin
         repeat (25) send_random_cmd(1'b0);
         wait_all_returned();
      end
   endtask

   task automatic test_tick_wrap(input int unsigned count);
      tx_idle  = 1'b1;
      rx_idle  = 1'b1;
      now_tick = 16'hffc0;
      repeat (count) send_random_cmd(1'b1);
   endtask

   task automatic test_back_to_back(input int unsigned count);
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      repeat (count) send_random_cmd(1'b0);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      table_rsp_type want;
      table_rsp_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_rsp_q.size() == 0) begin
            $display("%0t: unexpected response word 0x%0h", $time, rsp_tdata);
            mismatches++;
         end else begin
            want = pending_rsp_q.pop_front();
            check_field("hit",        want.hit,        got.hit);
            check_field("slot",       want.slot,       got.slot);
            check_field("out_con",    want.out_con,    got.out_con);
            check_field("out_led",    want.out_led,    got.out_led);
            check_field("any_active", want.any_active, got.any_active);
            check_field("pad",        0,               got.pad);
            rsp_checked++;
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (rx_idle && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      job_live     = '0;
      rr_next      = 0;
      stream_flag  = 1'b0;
      now_tick     = '0;
      tx_idle      = 1'b1;
      rx_idle      = 1'b1;
      mismatches   = 0;
      words_sent   = 0;
      rsp_checked  = 0;
      emits_issued = 0;
      find_hits    = 0;
      alloc_full   = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_mix(600);
      test_drain_between_bursts();
      test_tick_wrap(500);
      test_back_to_back(500);

      wait_all_returned();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d command words sent, %0d response words checked (all five modes, spare codes,",
               words_sent, rsp_checked);
      $display("tick wrap); %0d emits issued a job, %0d finds matched, %0d allocs saw a full table",
               emits_issued, find_hits, alloc_full);
      if (mismatches == 0 && pending_rsp_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
